// File: rtl/core/byte_level_token_text_decoder_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef BYTE_LEVEL_TOKEN_TEXT_DECODER_MACROS_SVH
`define BYTE_LEVEL_TOKEN_TEXT_DECODER_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define BLTTD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that implies another one in the same cycle.
`define BLTTD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/blttd_pkg.sv
`default_nettype none

package blttd_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TRUNC    = 2'd1,
    STATUS_BAD_LEAD = 2'd2,
    STATUS_UNMAPPED = 2'd3
  } status_t;

  localparam logic [7:0] MARK_B0 = 8'hE2;
  localparam logic [7:0] MARK_B1 = 8'h96;
  localparam logic [7:0] MARK_B2 = 8'h81;
  localparam logic [7:0] SPACE   = 8'h20;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       run_last;
    logic       text_end;
  } result_t;

  // All results caused by one input byte, the first one in entry 0.
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } bundle_t;

  // Inverse of the byte-to-unicode table: bit 8 says the code point is mapped.
  function automatic logic [8:0] inverse_map(input logic [20:0] cp);
    logic [7:0] lo;
    logic [8:0] r;
    lo = cp[7:0];
    r  = 9'd0;
    if (cp[20:8] == 13'd0 &&
        (lo inside {[8'd33:8'd126], [8'd161:8'd172], [8'd174:8'd255]})) begin
      r = {1'b1, lo};
    end else if (cp[20:8] == 13'd1 && lo <= 8'd67) begin
      if (lo < 8'd33) begin
        r = {1'b1, lo};
      end else if (lo < 8'd67) begin
        r = {1'b1, lo + 8'd94};
      end else begin
        r = {1'b1, 8'd173};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/blttd_decode.sv
`default_nettype none
`include "byte_level_token_text_decoder_macros.svh"

module blttd_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear,
  input  wire logic              step,
  input  wire logic              mode,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output blttd_pkg::bundle_t     bundle
);
  import blttd_pkg::*;

  logic [20:0] code_accum, code_accum_next;
  logic [1:0]  bytes_left, bytes_left_next;
  logic [1:0]  marker_matched, marker_matched_next;
  logic        discarding, discarding_next;

  logic [20:0] acc;
  logic [1:0]  left;
  logic        lead_bad;
  logic [8:0]  mapped;

  always_comb begin
    code_accum_next     = code_accum;
    bytes_left_next     = bytes_left;
    marker_matched_next = marker_matched;
    discarding_next     = discarding;
    bundle              = '0;
    acc                 = code_accum;
    left                = bytes_left;
    lead_bad            = 1'b0;
    mapped              = 9'd0;

    if (mode) begin
      if (discarding) begin
        if (in_last) begin
          discarding_next = 1'b0;
        end
      end else begin
        if (bytes_left == 2'd0) begin
          if (in_byte[7] == 1'b0) begin
            acc = {13'd0, in_byte};
          end else if ((in_byte & 8'hE0) == 8'hC0) begin
            acc  = {16'd0, in_byte[4:0]};
            left = 2'd1;
          end else if ((in_byte & 8'hF0) == 8'hE0) begin
            acc  = {17'd0, in_byte[3:0]};
            left = 2'd2;
          end else if ((in_byte & 8'hF8) == 8'hF0) begin
            acc  = {18'd0, in_byte[2:0]};
            left = 2'd3;
          end else begin
            lead_bad = 1'b1;
          end
        end else begin
          acc  = {code_accum[14:0], in_byte[5:0]};
          left = bytes_left - 2'd1;
        end
        mapped = inverse_map(acc);

        if (lead_bad || (left != 2'd0 && in_last) || (left == 2'd0 && !mapped[8])) begin
          // Error word: clear everything and drop the rest of the string.
          code_accum_next       = '0;
          bytes_left_next       = '0;
          discarding_next       = !in_last;
          bundle.count          = 2'd1;
          bundle.res[0].run_last = 1'b1;
          bundle.res[0].text_end = 1'b1;
          if (lead_bad) begin
            bundle.res[0].status = STATUS_BAD_LEAD;
          end else if (left != 2'd0) begin
            bundle.res[0].status = STATUS_TRUNC;
          end else begin
            bundle.res[0].status = STATUS_UNMAPPED;
          end
        end else if (left != 2'd0) begin
          code_accum_next = acc;
          bytes_left_next = left;
        end else begin
          code_accum_next        = '0;
          bytes_left_next        = '0;
          bundle.count           = 2'd1;
          bundle.res[0].out_byte = mapped[7:0];
          bundle.res[0].status   = STATUS_OK;
          bundle.res[0].run_last = 1'b1;
          bundle.res[0].text_end = in_last;
        end
      end
    end else begin
      if (marker_matched == 2'd2 && in_byte == MARK_B2) begin
        marker_matched_next    = 2'd0;
        bundle.count           = 2'd1;
        bundle.res[0].out_byte = SPACE;
        bundle.res[0].run_last = 1'b1;
        bundle.res[0].text_end = in_last;
      end else if (marker_matched == 2'd1 && in_byte == MARK_B1 && !in_last) begin
        marker_matched_next = 2'd2;
      end else begin
        // Flush any pending marker bytes, then look at this byte afresh.
        bundle.res[0].out_byte = MARK_B0;
        bundle.res[1].out_byte = MARK_B1;
        if (in_byte == MARK_B0 && !in_last) begin
          marker_matched_next = 2'd1;
          bundle.count        = marker_matched;
          if (marker_matched != 2'd0) begin
            bundle.res[marker_matched - 2'd1].run_last = 1'b1;
          end
        end else begin
          marker_matched_next                        = 2'd0;
          bundle.count                               = marker_matched + 2'd1;
          bundle.res[marker_matched].out_byte        = in_byte;
          bundle.res[marker_matched].run_last        = 1'b1;
          bundle.res[marker_matched].text_end        = in_last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      code_accum     <= '0;
      bytes_left     <= '0;
      marker_matched <= '0;
      discarding     <= 1'b0;
    end else if (step) begin
      code_accum     <= code_accum_next;
      bytes_left     <= bytes_left_next;
      marker_matched <= marker_matched_next;
      discarding     <= discarding_next;
    end
  end

  `BLTTD_ASSERT_IMPL(a_err_word, clk, rst, step && bundle.count != 2'd0 && bundle.res[0].status != STATUS_OK, bundle.count == 2'd1 && bundle.res[0].out_byte == 8'd0 && bundle.res[0].text_end, "error word malformed")
  `BLTTD_ASSERT_IMPL(a_discard_mode, clk, rst, discarding, mode && marker_matched == 2'd0, "discarding outside byte-level mode")

endmodule

`default_nettype wire

// File: rtl/core/blttd_out_queue.sv
`default_nettype none
`include "byte_level_token_text_decoder_macros.svh"

module blttd_out_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load_en,
  input  blttd_pkg::bundle_t      bundle,
  output logic                    load_ready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output blttd_pkg::result_t      head
);
  import blttd_pkg::*;

  result_t [2:0] res;
  logic [1:0]    cnt;
  logic          take;

  assign m_tvalid   = (cnt != 2'd0);
  assign head       = res[0];
  assign take       = m_tvalid && m_tready;
  // Room for a new bundle once the last pending word leaves this cycle.
  assign load_ready = (cnt == 2'd0) || (cnt == 2'd1 && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load_en) begin
      cnt <= bundle.count;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      res <= bundle.res;
    end else if (take) begin
      res <= {res[2], res[2], res[1]};
    end
  end

  `BLTTD_ASSERT_IMPL(a_load_room, clk, rst, load_en, cnt == 2'd0 || (cnt == 2'd1 && take), "bundle loaded over pending words")
  `BLTTD_ASSERT_IMPL(a_final_run_last, clk, rst, cnt == 2'd1, res[0].run_last, "final word of a byte lacks run_last")
  `BLTTD_ASSERT_IMPL(a_early_run_last, clk, rst, cnt > 2'd1, !res[0].run_last && !res[0].text_end, "run_last before final word")

endmodule

`default_nettype wire

// File: rtl/core/byte_level_token_text_decoder.sv
// Path: a byte accepted into the input register is decoded there and its
// result words are loaded into the result queue, whose head drives m_tvalid;
// the byte waits in the input register while the queue has no room for it.
// Throughput: one byte per cycle while each byte gives at most one word and
// m_tready is high; after a byte that gives several words, the next byte waits until the last of them leaves.
// Reset (rst, synchronous): byte-level mode on, decode state cleared, no
// words pending.
`default_nettype none

module byte_level_token_text_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: bit 0 is byte_level_mode.
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  // Input words.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,   // last_byte
  // Result words.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_byte, [9:8] status, rest zero
  output logic             m_tuser,   // run_last
  output logic             m_tlast    // text_end
);
  import blttd_pkg::*;

  // Mode register; any write also clears the decode state.
  logic       mode;

  // Input register: holds one byte until the queue can take its results.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  logic       advance;
  logic       load_ready;
  bundle_t    bundle;
  result_t    head;

  assign advance  = in_valid && load_ready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // The decode step runs in the cycle its results move into the queue.
  blttd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_we),
    .step    (advance),
    .mode    (mode),
    .in_byte (in_byte),
    .in_last (in_last),
    .bundle  (bundle)
  );

  blttd_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .load_en    (advance),
    .bundle     (bundle),
    .load_ready (load_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .head       (head)
  );

  assign m_tdata = {6'd0, head.status, head.out_byte};
  assign m_tuser = head.run_last;
  assign m_tlast = head.text_end;

endmodule

`default_nettype wire
